[sv/crcst_pkg.sv]
// Shared types, codes and the CRC-16 step function of the CRC segment transfer engine.
package crcst_pkg;

  // Operation codes of an input beat
  localparam logic [2:0] OP_START_RX = 3'd0;
  localparam logic [2:0] OP_START_TX = 3'd1;
  localparam logic [2:0] OP_LINK     = 3'd2;
  localparam logic [2:0] OP_TIMEOUT  = 3'd3;
  localparam logic [2:0] OP_LOAD     = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_LINK   = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Segment finish status
  localparam logic [1:0] ST_SUCCESS = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_NAK     = 2'd2;
  localparam logic [1:0] ST_ABORT   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_MAX_ATTEMPTS = 3'd0;
  localparam logic [2:0] REG_RX_CODE      = 3'd1;
  localparam logic [2:0] REG_TX_CODE      = 3'd2;
  localparam logic [2:0] REG_OK_CODE      = 3'd3;
  localparam logic [2:0] REG_RESEND_CODE  = 3'd4;
  localparam logic [2:0] REG_ABORT_CODE   = 3'd5;
  localparam logic [2:0] REG_ACK_CODE     = 3'd6;

  // Reflected CRC-16 polynomial
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Link protocol phase
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ACK_ID,
    PH_ACK_LEN,
    PH_RECV,
    PH_ACK_RESEND,
    PH_ACK_ABORT,
    PH_ACK_OK
  } phase_e;

  // Beat sequencer state
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RD_WAIT,
    SEQ_LEN_HI,
    SEQ_TX
  } seq_e;

  // Configuration register contents
  typedef struct packed {
    logic [7:0] max_attempts;
    logic [7:0] rx_segment_code;
    logic [7:0] tx_segment_code;
    logic [7:0] reply_ok_code;
    logic [7:0] reply_resend_code;
    logic [7:0] reply_abort_code;
    logic [7:0] ack_code;
  } cfg_t;

  // One byte of CRC-16 update, bit at a time
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/crcst_store.sv]
// Segment byte store: one write port, one read port with registered read data.
module crcst_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/crcst_cfg.sv]
// APB-style configuration registers of the CRC segment transfer engine.
module crcst_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output crcst_pkg::cfg_t   cfg_o
);

  crcst_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]      idx;
  logic            wr_en;
  logic [7:0]      rd_byte;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        crcst_pkg::REG_MAX_ATTEMPTS: cfg_d.max_attempts      = pwdata[7:0];
        crcst_pkg::REG_RX_CODE:      cfg_d.rx_segment_code   = pwdata[7:0];
        crcst_pkg::REG_TX_CODE:      cfg_d.tx_segment_code   = pwdata[7:0];
        crcst_pkg::REG_OK_CODE:      cfg_d.reply_ok_code     = pwdata[7:0];
        crcst_pkg::REG_RESEND_CODE:  cfg_d.reply_resend_code = pwdata[7:0];
        crcst_pkg::REG_ABORT_CODE:   cfg_d.reply_abort_code  = pwdata[7:0];
        crcst_pkg::REG_ACK_CODE:     cfg_d.ack_code          = pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      crcst_pkg::REG_MAX_ATTEMPTS: rd_byte = cfg_q.max_attempts;
      crcst_pkg::REG_RX_CODE:      rd_byte = cfg_q.rx_segment_code;
      crcst_pkg::REG_TX_CODE:      rd_byte = cfg_q.tx_segment_code;
      crcst_pkg::REG_OK_CODE:      rd_byte = cfg_q.reply_ok_code;
      crcst_pkg::REG_RESEND_CODE:  rd_byte = cfg_q.reply_resend_code;
      crcst_pkg::REG_ABORT_CODE:   rd_byte = cfg_q.reply_abort_code;
      crcst_pkg::REG_ACK_CODE:     rd_byte = cfg_q.ack_code;
      default:                     rd_byte = 8'h00;
    endcase
  end

  assign prdata = {24'h000000, rd_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_attempts      <= 8'd5;
      cfg_q.rx_segment_code   <= 8'd1;
      cfg_q.tx_segment_code   <= 8'd2;
      cfg_q.reply_ok_code     <= 8'd3;
      cfg_q.reply_resend_code <= 8'd4;
      cfg_q.reply_abort_code  <= 8'd5;
      cfg_q.ack_code          <= 8'd6;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/crcst_ctrl.sv]
// Link protocol control: phase tracking, CRC check, retries and result sequencing.
module crcst_ctrl #(
  parameter int MAX_SEGMENT = 32,
  parameter int AW          = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crcst_pkg::cfg_t cfg_i,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      op_i,
  input  logic [6:0]      seg_length_i,
  input  logic [5:0]      slot_i,
  input  logic [7:0]      byte_in_i,
  output logic            result_valid_o,
  output logic [1:0]      kind_o,
  output logic [7:0]      byte_out_o,
  output logic [1:0]      status_o,
  output logic            last_o,
  output logic            mem_we_o,
  output logic [AW-1:0]   mem_waddr_o,
  output logic [7:0]      mem_wdata_o,
  output logic            mem_re_o,
  output logic [AW-1:0]   mem_raddr_o,
  input  logic [7:0]      mem_rdata_i
);

  localparam logic [6:0] MaxSeg = 7'(MAX_SEGMENT);

  crcst_pkg::seq_e   seq_q, seq_d;
  crcst_pkg::phase_e phase_q, phase_d;
  logic        sending_q, sending_d;
  logic [6:0]  len_q, len_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  tries_q, tries_d;
  logic [6:0]  tx_idx_q, tx_idx_d;
  logic        rd_zero_q, rd_zero_d;
  logic        res_valid_q, res_valid_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [1:0]  status_q, status_d;
  logic        last_q, last_d;

  logic        accept;
  logic        is_ack;
  logic        slot_ok;
  logic        tx_last;
  logic [6:0]  len_sat;
  logic [6:0]  tx_next;
  logic [7:0]  tries_dec;

  assign accept    = start && (seq_q == crcst_pkg::SEQ_IDLE);
  assign busy      = (seq_q != crcst_pkg::SEQ_IDLE);
  assign is_ack    = (byte_in_i == cfg_i.ack_code);
  assign slot_ok   = ({1'b0, slot_i} < MaxSeg);
  assign tx_last   = (tx_idx_q == len_q - 7'd1);
  assign tx_next   = tx_idx_q + 7'd1;
  assign len_sat   = (seg_length_i > MaxSeg) ? MaxSeg : seg_length_i;
  assign tries_dec = tries_q - 8'd1;

  // Sequencer next state
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      crcst_pkg::SEQ_IDLE: begin
        if (accept) begin
          if (op_i == crcst_pkg::OP_READ) begin
            seq_d = crcst_pkg::SEQ_RD_WAIT;
          end else if (op_i == crcst_pkg::OP_LINK && is_ack &&
                       phase_q == crcst_pkg::PH_ACK_ID) begin
            seq_d = crcst_pkg::SEQ_LEN_HI;
          end else if (op_i == crcst_pkg::OP_LINK && is_ack && sending_q &&
                       len_q != 7'd0 &&
                       (phase_q inside {crcst_pkg::PH_ACK_LEN,
                                        crcst_pkg::PH_ACK_RESEND})) begin
            seq_d = crcst_pkg::SEQ_TX;
          end
        end
      end
      crcst_pkg::SEQ_RD_WAIT: seq_d = crcst_pkg::SEQ_IDLE;
      crcst_pkg::SEQ_LEN_HI:  seq_d = crcst_pkg::SEQ_IDLE;
      crcst_pkg::SEQ_TX: begin
        if (tx_last) begin
          seq_d = crcst_pkg::SEQ_IDLE;
        end
      end
      default: seq_d = crcst_pkg::SEQ_IDLE;
    endcase
  end

  // Datapath, store accesses and result beats
  always_comb begin
    phase_d     = phase_q;
    sending_d   = sending_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    sum_d       = sum_q;
    tries_d     = tries_q;
    tx_idx_d    = tx_idx_q;
    rd_zero_d   = rd_zero_q;
    res_valid_d = 1'b0;
    kind_d      = crcst_pkg::KIND_LINK;
    byte_d      = 8'h00;
    status_d    = crcst_pkg::ST_SUCCESS;
    last_d      = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot_i[AW-1:0];
    mem_wdata_o = byte_in_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = slot_i[AW-1:0];

    case (seq_q)
      crcst_pkg::SEQ_IDLE: begin
        if (accept) begin
          case (op_i)
            crcst_pkg::OP_START_RX, crcst_pkg::OP_START_TX: begin
              if (phase_q == crcst_pkg::PH_IDLE) begin
                len_d       = len_sat;
                sending_d   = op_i[0];
                tries_d     = cfg_i.max_attempts;
                cnt_d       = 7'd0;
                crc_d       = 16'h0000;
                sum_d       = 16'h0000;
                res_valid_d = 1'b1;
                byte_d      = op_i[0] ? cfg_i.tx_segment_code : cfg_i.rx_segment_code;
                last_d      = 1'b1;
                phase_d     = crcst_pkg::PH_ACK_ID;
              end
            end
            crcst_pkg::OP_LINK: begin
              if (phase_q == crcst_pkg::PH_RECV) begin
                // data bytes go to the store (count below length keeps it in range)
                if (cnt_q < len_q) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = cnt_q[AW-1:0];
                  crc_d       = crcst_pkg::crc_step(crc_q, byte_in_i);
                end else if (cnt_q == len_q) begin
                  sum_d[7:0] = byte_in_i;
                end else begin
                  sum_d[15:8] = byte_in_i;
                end
                cnt_d = cnt_q + 7'd1;
                // checksum high byte closes the attempt
                if (cnt_q == len_q + 7'd1) begin
                  res_valid_d = 1'b1;
                  last_d      = 1'b1;
                  if (crc_q == {byte_in_i, sum_q[7:0]}) begin
                    byte_d  = cfg_i.reply_ok_code;
                    phase_d = crcst_pkg::PH_ACK_OK;
                  end else begin
                    tries_d = tries_dec;
                    if (tries_dec != 8'd0) begin
                      byte_d  = cfg_i.reply_resend_code;
                      phase_d = crcst_pkg::PH_ACK_RESEND;
                    end else begin
                      byte_d  = cfg_i.reply_abort_code;
                      phase_d = crcst_pkg::PH_ACK_ABORT;
                    end
                  end
                end
              end else if (phase_q != crcst_pkg::PH_IDLE) begin
                if (!is_ack) begin
                  res_valid_d = 1'b1;
                  kind_d      = crcst_pkg::KIND_FINISH;
                  status_d    = crcst_pkg::ST_NAK;
                  last_d      = 1'b1;
                  phase_d     = crcst_pkg::PH_IDLE;
                end else begin
                  case (phase_q)
                    crcst_pkg::PH_ACK_ID: begin
                      // low length byte now, high byte next cycle
                      res_valid_d = 1'b1;
                      byte_d      = {1'b0, len_q};
                      phase_d     = crcst_pkg::PH_ACK_LEN;
                    end
                    crcst_pkg::PH_ACK_LEN, crcst_pkg::PH_ACK_RESEND: begin
                      crc_d   = 16'h0000;
                      sum_d   = 16'h0000;
                      cnt_d   = 7'd0;
                      phase_d = crcst_pkg::PH_RECV;
                      if (sending_q) begin
                        cnt_d = len_q;
                        if (len_q != 7'd0) begin
                          mem_re_o    = 1'b1;
                          mem_raddr_o = '0;
                          tx_idx_d    = 7'd0;
                        end
                      end
                    end
                    crcst_pkg::PH_ACK_ABORT: begin
                      res_valid_d = 1'b1;
                      kind_d      = crcst_pkg::KIND_FINISH;
                      status_d    = crcst_pkg::ST_ABORT;
                      last_d      = 1'b1;
                      phase_d     = crcst_pkg::PH_IDLE;
                    end
                    crcst_pkg::PH_ACK_OK: begin
                      res_valid_d = 1'b1;
                      kind_d      = crcst_pkg::KIND_FINISH;
                      status_d    = crcst_pkg::ST_SUCCESS;
                      last_d      = 1'b1;
                      phase_d     = crcst_pkg::PH_IDLE;
                    end
                    default: phase_d = crcst_pkg::PH_IDLE;
                  endcase
                end
              end
            end
            crcst_pkg::OP_TIMEOUT: begin
              if (phase_q != crcst_pkg::PH_IDLE) begin
                res_valid_d = 1'b1;
                kind_d      = crcst_pkg::KIND_FINISH;
                status_d    = crcst_pkg::ST_TIMEOUT;
                last_d      = 1'b1;
                phase_d     = crcst_pkg::PH_IDLE;
              end
            end
            crcst_pkg::OP_LOAD: begin
              mem_we_o = slot_ok;
            end
            crcst_pkg::OP_READ: begin
              mem_re_o  = 1'b1;
              rd_zero_d = !slot_ok;
            end
            default: ;
          endcase
        end
      end
      crcst_pkg::SEQ_RD_WAIT: begin
        res_valid_d = 1'b1;
        kind_d      = crcst_pkg::KIND_READ;
        byte_d      = rd_zero_q ? 8'h00 : mem_rdata_i;
        last_d      = 1'b1;
      end
      crcst_pkg::SEQ_LEN_HI: begin
        res_valid_d = 1'b1;
        last_d      = 1'b1;
      end
      crcst_pkg::SEQ_TX: begin
        // stream one stored byte a cycle, next read issued alongside
        res_valid_d = 1'b1;
        byte_d      = mem_rdata_i;
        last_d      = tx_last;
        crc_d       = crcst_pkg::crc_step(crc_q, mem_rdata_i);
        if (!tx_last) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = tx_next[AW-1:0];
          tx_idx_d    = tx_next;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= crcst_pkg::SEQ_IDLE;
      phase_q     <= crcst_pkg::PH_IDLE;
      sending_q   <= 1'b0;
      len_q       <= 7'd0;
      cnt_q       <= 7'd0;
      crc_q       <= 16'h0000;
      sum_q       <= 16'h0000;
      tries_q     <= 8'd0;
      tx_idx_q    <= 7'd0;
      rd_zero_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      sending_q   <= sending_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      crc_q       <= crc_d;
      sum_q       <= sum_d;
      tries_q     <= tries_d;
      tx_idx_q    <= tx_idx_d;
      rd_zero_q   <= rd_zero_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    byte_q   <= byte_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign byte_out_o     = byte_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

endmodule

[sv/crc_segment_transfer_engine_unit.sv]
// Top level of the CRC segment transfer engine.
// Usage:
//   Commands enter on start/busy: a beat is taken when start is high and busy
//   is low. op selects start receive, start transmit, link byte, link timeout,
//   load byte or read byte. Results leave one per cycle on result_valid_o with
//   kind_o, byte_out_o, status_o and last_o; last_o marks the final result of
//   a command. Results cannot be held off by the receiver.
//   A read byte or a transmit burst first waits on the store's read register.
//   Most commands return to idle at once; a read byte passes through the read
//   wait state, the length announcement through the length-high state, and a
//   transmit burst of N stored bytes stays busy until its last byte, paced by
//   the single read port of the segment store (one byte read and one CRC byte
//   step per cycle). Configuration registers (max attempts and the link byte
//   codes) sit on the APB-style port, byte address 4*i; the user must write
//   them only while the engine is idle, unchecked by the block. Reset puts the
//   link in idle and loads the default codes; the segment store is not
//   cleared and must be written before it is read.
module crc_segment_transfer_engine_unit #(
  parameter int MAX_SEGMENT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [6:0]  seg_length_i,
  input  logic [5:0]  slot_i,
  input  logic [7:0]  byte_in_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_out_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam int AW = (MAX_SEGMENT > 1) ? $clog2(MAX_SEGMENT) : 1;

  crcst_pkg::cfg_t cfg;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [7:0]      mem_rdata;

  // Configuration registers
  crcst_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Segment store
  crcst_store #(
    .DEPTH (MAX_SEGMENT),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Protocol control
  crcst_ctrl #(
    .MAX_SEGMENT (MAX_SEGMENT),
    .AW          (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .seg_length_i   (seg_length_i),
    .slot_i         (slot_i),
    .byte_in_i      (byte_in_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .byte_out_o     (byte_out_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

endmodule

[sim/tb_crc_segment_transfer_engine_unit.sv]
// Self-checking testbench of the CRC segment transfer engine: directed table, then random segments.
`timescale 1ns / 1ps

module tb_crc_segment_transfer_engine_unit;
  import crcst_pkg::*;

  localparam int          MAX_SEG      = 32;
  localparam int          DIR_ROWS     = 28;
  localparam int          PHASE_ITEMS  = 36;
  localparam int          NUM_PHASES   = 6;
  localparam int          SETTLE_CYC   = 40;
  localparam int unsigned LIMIT_CYCLES = 400000;

  // Unused op codes, ignored by the engine
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // How a command beat is checked
  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_ONE
  } chk_e;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] len;
    logic [5:0] slot;
    logic [7:0] data;
    chk_e       chk;
    logic [1:0] kind;
    logic [7:0] rbyte;
    logic [1:0] status;
  } beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } link_res_t;

  // DUT signals
  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [2:0]  op_i;
  logic [6:0]  seg_length_i;
  logic [5:0]  slot_i;
  logic [7:0]  byte_in_i;
  logic        result_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  byte_out_o;
  logic [1:0]  status_o;
  logic        last_o;

  // Check mode of the beat on the bus
  chk_e       cur_chk;
  logic [1:0] cur_kind;
  logic [7:0] cur_byte;
  logic [1:0] cur_status;

  // Engine state as predicted
  cfg_t        cfg;
  phase_e      link_ph;
  logic        tx_mode;
  logic [6:0]  act_len;
  logic [6:0]  byte_cnt;
  logic [15:0] crc_acc;
  logic [15:0] sum_rx;
  logic [7:0]  tries;
  logic [7:0]  seg_mem [MAX_SEG];

  link_res_t   step_out [$];
  link_res_t   due_q [$];
  beat_t       dir_tab [DIR_ROWS];

  int unsigned err_cnt;
  int unsigned cyc_cnt;
  int unsigned work_items;
  logic        no_gap;

  crc_segment_transfer_engine_unit #(
    .MAX_SEGMENT(MAX_SEG)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .seg_length_i  (seg_length_i),
    .slot_i        (slot_i),
    .byte_in_i     (byte_in_i),
    .result_valid_o(result_valid_o),
    .kind_o        (kind_o),
    .byte_out_o    (byte_out_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Reflected CRC-16, LSB first, one bit per step
  function automatic logic [15:0] crc_add(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // Predict the results of one command beat into step_out
  task automatic advance_link(input logic [2:0] op, input logic [6:0] len,
                              input logic [5:0] slot, input logic [7:0] b);
    step_out.delete();
    case (op)
      OP_START_RX, OP_START_TX: begin
        if (link_ph == PH_IDLE) begin
          act_len  = (len > MAX_SEG) ? 7'(MAX_SEG) : len;
          tx_mode  = (op == OP_START_TX);
          tries    = cfg.max_attempts;
          byte_cnt = '0;
          crc_acc  = '0;
          sum_rx   = '0;
          step_out.push_back('{KIND_LINK, tx_mode ? cfg.tx_segment_code : cfg.rx_segment_code,
                               ST_SUCCESS, 1'b0});
          link_ph  = PH_ACK_ID;
        end
      end
      OP_LINK: begin
        if (link_ph == PH_RECV) begin
          // data bytes, then checksum low and high
          if (byte_cnt < act_len) begin
            if (byte_cnt < MAX_SEG) seg_mem[byte_cnt[4:0]] = b;
            crc_acc = crc_add(crc_acc, b);
          end else if (byte_cnt == act_len) begin
            sum_rx[7:0] = b;
          end else begin
            sum_rx[15:8] = b;
          end
          byte_cnt = byte_cnt + 7'd1;
          if (byte_cnt == act_len + 7'd2) begin
            if (crc_acc == sum_rx) begin
              step_out.push_back('{KIND_LINK, cfg.reply_ok_code, ST_SUCCESS, 1'b0});
              link_ph = PH_ACK_OK;
            end else begin
              tries = tries - 8'd1;
              if (tries != 0) begin
                step_out.push_back('{KIND_LINK, cfg.reply_resend_code, ST_SUCCESS, 1'b0});
                link_ph = PH_ACK_RESEND;
              end else begin
                step_out.push_back('{KIND_LINK, cfg.reply_abort_code, ST_SUCCESS, 1'b0});
                link_ph = PH_ACK_ABORT;
              end
            end
          end
        end else if (link_ph != PH_IDLE) begin
          if (b != cfg.ack_code) begin
            step_out.push_back('{KIND_FINISH, 8'h00, ST_NAK, 1'b0});
            link_ph = PH_IDLE;
          end else begin
            case (link_ph)
              PH_ACK_ID: begin
                step_out.push_back('{KIND_LINK, {1'b0, act_len}, ST_SUCCESS, 1'b0});
                step_out.push_back('{KIND_LINK, 8'h00, ST_SUCCESS, 1'b0});
                link_ph = PH_ACK_LEN;
              end
              PH_ACK_LEN, PH_ACK_RESEND: begin
                // new attempt; transmit bursts the stored data
                crc_acc  = '0;
                sum_rx   = '0;
                byte_cnt = '0;
                if (tx_mode) begin
                  for (int i = 0; i < act_len; i++) begin
                    step_out.push_back('{KIND_LINK, seg_mem[i], ST_SUCCESS, 1'b0});
                    crc_acc = crc_add(crc_acc, seg_mem[i]);
                  end
                  byte_cnt = act_len;
                end
                link_ph = PH_RECV;
              end
              PH_ACK_ABORT: begin
                step_out.push_back('{KIND_FINISH, 8'h00, ST_ABORT, 1'b0});
                link_ph = PH_IDLE;
              end
              PH_ACK_OK: begin
                step_out.push_back('{KIND_FINISH, 8'h00, ST_SUCCESS, 1'b0});
                link_ph = PH_IDLE;
              end
              default: link_ph = PH_IDLE;
            endcase
          end
        end
      end
      OP_TIMEOUT: begin
        if (link_ph != PH_IDLE) begin
          step_out.push_back('{KIND_FINISH, 8'h00, ST_TIMEOUT, 1'b0});
          link_ph = PH_IDLE;
        end
      end
      OP_LOAD: begin
        if (slot < MAX_SEG) seg_mem[slot[4:0]] = b;
      end
      OP_READ: begin
        step_out.push_back('{KIND_READ, (slot < MAX_SEG) ? seg_mem[slot[4:0]] : 8'h00,
                             ST_SUCCESS, 1'b0});
      end
      default: ;
    endcase
    if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
  endtask

  // Result check and command prediction, both at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h status %0d",
                                    kind_o, byte_out_o, status_o));
        end else begin
          if (kind_o !== due_q[0].kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind_o, due_q[0].kind));
          if (byte_out_o !== due_q[0].data)
            report_mismatch($sformatf("byte %02h, want %02h", byte_out_o, due_q[0].data));
          if (status_o !== due_q[0].status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, due_q[0].status));
          if (last_o !== due_q[0].last)
            report_mismatch($sformatf("last %0d, want %0d", last_o, due_q[0].last));
          void'(due_q.pop_front());
        end
      end
      if (start && !busy) begin
        advance_link(op_i, seg_length_i, slot_i, byte_in_i);
        case (cur_chk)
          CHK_PRED: foreach (step_out[i]) due_q.push_back(step_out[i]);
          CHK_ONE:  due_q.push_back('{cur_kind, cur_byte, cur_status, 1'b1});
          default:  ;
        endcase
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One command beat; returns at the falling edge after it was taken, start still high
  task automatic send_beat(input beat_t r);
    if (!no_gap && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    start        <= 1'b1;
    op_i         <= r.op;
    seg_length_i <= r.len;
    slot_i       <= r.slot;
    byte_in_i    <= r.data;
    cur_chk      <= r.chk;
    cur_kind     <= r.kind;
    cur_byte     <= r.rbyte;
    cur_status   <= r.status;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Register write: setup then access; leaves psel high for a following write
  task automatic apb_write(input logic [2:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_MAX_ATTEMPTS: cfg.max_attempts      = val;
      REG_RX_CODE:      cfg.rx_segment_code   = val;
      REG_TX_CODE:      cfg.tx_segment_code   = val;
      REG_OK_CODE:      cfg.reply_ok_code     = val;
      REG_RESEND_CODE:  cfg.reply_resend_code = val;
      REG_ABORT_CODE:   cfg.reply_abort_code  = val;
      REG_ACK_CODE:     cfg.ack_code          = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_regs(input logic [7:0] m, input logic [7:0] rx, input logic [7:0] tx,
                           input logic [7:0] ok, input logic [7:0] rs, input logic [7:0] ab,
                           input logic [7:0] ack);
    apb_write(REG_MAX_ATTEMPTS, m);
    apb_write(REG_RX_CODE, rx);
    apb_write(REG_TX_CODE, tx);
    apb_write(REG_OK_CODE, ok);
    apb_write(REG_RESEND_CODE, rs);
    apb_write(REG_ABORT_CODE, ab);
    apb_write(REG_ACK_CODE, ack);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Close any open segment, drain results, let the engine go quiet
  task automatic settle();
    beat_t bt;
    bt     = '0;
    bt.chk = CHK_PRED;
    if (link_ph != PH_IDLE) begin
      bt.op = OP_TIMEOUT;
      send_beat(bt);
    end
    start <= 1'b0;
    while (due_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // Random command with any op code, including the spare ones
  task automatic send_noise();
    beat_t bt;
    bt      = '0;
    bt.chk  = CHK_PRED;
    bt.op   = 3'($urandom_range(0, 7));
    bt.len  = 7'($urandom_range(0, 127));
    bt.slot = 6'($urandom_range(0, 63));
    bt.data = 8'($urandom_range(0, 255));
    send_beat(bt);
  endtask

  // One well-formed segment with random content, broken now and then
  task automatic drive_segment();
    beat_t       bt;
    int unsigned p;
    logic        good;
    bt      = '0;
    bt.chk  = CHK_PRED;
    p       = $urandom_range(0, 99);
    bt.op   = $urandom_range(0, 1) ? OP_START_TX : OP_START_RX;
    bt.len  = (p < 70) ? 7'($urandom_range(0, 6)) :
              (p < 92) ? 7'($urandom_range(7, MAX_SEG)) : 7'($urandom_range(MAX_SEG + 1, 127));
    bt.slot = 6'($urandom_range(0, 63));
    bt.data = 8'($urandom_range(0, 255));
    send_beat(bt);
    work_items++;
    good = 1'b1;
    while (link_ph != PH_IDLE) begin
      bt.slot = 6'($urandom_range(0, 63));
      bt.data = 8'($urandom_range(0, 255));
      bt.len  = 7'($urandom_range(0, 127));
      p       = $urandom_range(0, 99);
      if (p < 6) begin
        // store access in the middle of a segment
        bt.op = $urandom_range(0, 1) ? OP_LOAD : OP_READ;
      end else if (p < 8) begin
        bt.op = $urandom_range(0, 1) ? OP_START_TX : OP_START_RX;
      end else if (p < 9) begin
        bt.op = OP_TIMEOUT;
      end else begin
        bt.op = OP_LINK;
        if (link_ph == PH_RECV) begin
          // checksum right most of the time
          if (byte_cnt == act_len) begin
            good = ($urandom_range(0, 99) < 60);
            if (good) bt.data = crc_acc[7:0];
          end else if (byte_cnt > act_len && good) begin
            bt.data = crc_acc[15:8];
          end
        end else if ($urandom_range(0, 99) < 93) begin
          bt.data = cfg.ack_code;
        end else begin
          bt.data = cfg.ack_code ^ 8'($urandom_range(1, 255));
        end
      end
      send_beat(bt);
      if (p < 6 || p >= 8) work_items++;
    end
  endtask

  initial begin
    beat_t bt;

    // Known values on every input from time zero
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    start        = 1'b0;
    op_i         = OP_TIMEOUT;
    seg_length_i = '0;
    slot_i       = '0;
    byte_in_i    = '0;
    cur_chk      = CHK_PRED;
    cur_kind     = KIND_LINK;
    cur_byte     = '0;
    cur_status   = ST_SUCCESS;
    err_cnt      = 0;
    cyc_cnt      = 0;
    work_items   = 0;
    no_gap       = 1'b0;

    // Reset values of the predicted state
    cfg      = '{8'd5, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6};
    link_ph  = PH_IDLE;
    tx_mode  = 1'b0;
    act_len  = '0;
    byte_cnt = '0;
    crc_acc  = '0;
    sum_rx   = '0;
    tries    = '0;
    foreach (seg_mem[i]) seg_mem[i] = '0;

    // Directed rows; typed results assume the reset codes
    dir_tab = '{
      '{OP_TIMEOUT,  7'd0,   6'd0,  8'h00, CHK_NONE, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_LINK,     7'd0,   6'd0,  8'h06, CHK_NONE, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_SPARE6,   7'd127, 6'd63, 8'hFF, CHK_NONE, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_SPARE7,   7'd0,   6'd0,  8'h00, CHK_NONE, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_READ,     7'd0,   6'd40, 8'h00, CHK_ONE,  KIND_READ,   8'h00, ST_SUCCESS},
      '{OP_LOAD,     7'd0,   6'd63, 8'hFF, CHK_NONE, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_READ,     7'd0,   6'd63, 8'h00, CHK_ONE,  KIND_READ,   8'h00, ST_SUCCESS},
      '{OP_LOAD,     7'd0,   6'd0,  8'hA5, CHK_NONE, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_READ,     7'd0,   6'd0,  8'h00, CHK_ONE,  KIND_READ,   8'hA5, ST_SUCCESS},
      '{OP_LOAD,     7'd0,   6'd31, 8'h00, CHK_NONE, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_READ,     7'd0,   6'd31, 8'h00, CHK_ONE,  KIND_READ,   8'h00, ST_SUCCESS},
      // empty receive segment, matching zero checksum
      '{OP_START_RX, 7'd0,   6'd0,  8'h00, CHK_ONE,  KIND_LINK,   8'h01, ST_SUCCESS},
      '{OP_LINK,     7'd0,   6'd0,  8'h06, CHK_PRED, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_LINK,     7'd0,   6'd0,  8'h06, CHK_NONE, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_LINK,     7'd0,   6'd0,  8'h00, CHK_NONE, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_LINK,     7'd0,   6'd0,  8'h00, CHK_ONE,  KIND_LINK,   8'h03, ST_SUCCESS},
      '{OP_LINK,     7'd0,   6'd0,  8'h06, CHK_ONE,  KIND_FINISH, 8'h00, ST_SUCCESS},
      // over-long segment is saturated, then times out
      '{OP_START_RX, 7'd127, 6'd0,  8'h00, CHK_ONE,  KIND_LINK,   8'h01, ST_SUCCESS},
      '{OP_LINK,     7'd0,   6'd0,  8'h06, CHK_PRED, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_LINK,     7'd0,   6'd0,  8'h06, CHK_NONE, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_TIMEOUT,  7'd0,   6'd0,  8'h00, CHK_ONE,  KIND_FINISH, 8'h00, ST_TIMEOUT},
      // non-ack on the ID byte
      '{OP_START_TX, 7'd3,   6'd0,  8'h00, CHK_ONE,  KIND_LINK,   8'h02, ST_SUCCESS},
      '{OP_LINK,     7'd0,   6'd0,  8'h07, CHK_ONE,  KIND_FINISH, 8'h00, ST_NAK},
      // transmit burst; a start while a segment is open is ignored
      '{OP_START_TX, 7'd2,   6'd0,  8'h00, CHK_ONE,  KIND_LINK,   8'h02, ST_SUCCESS},
      '{OP_START_RX, 7'd5,   6'd0,  8'h00, CHK_NONE, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_LINK,     7'd0,   6'd0,  8'h06, CHK_PRED, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_LINK,     7'd0,   6'd0,  8'h06, CHK_PRED, KIND_LINK,   8'h00, ST_SUCCESS},
      '{OP_TIMEOUT,  7'd0,   6'd0,  8'h00, CHK_ONE,  KIND_FINISH, 8'h00, ST_TIMEOUT}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill the whole store so no read ever hits an unwritten byte
    bt     = '0;
    bt.chk = CHK_PRED;
    bt.op  = OP_LOAD;
    for (int i = 0; i < MAX_SEG; i++) begin
      bt.slot = 6'(i);
      bt.data = 8'($urandom_range(0, 255));
      send_beat(bt);
    end

    foreach (dir_tab[i]) send_beat(dir_tab[i]);
    settle();

    // Random phases over several register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;
        1: load_regs(8'd1, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'hFF);
        2: load_regs(8'd255, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00);
        3: load_regs(8'd2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        // zero attempts wraps to 256 tries
        4: load_regs(8'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: load_regs(8'($urandom_range(1, 4)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
      endcase
      no_gap = (ph == 3);
      work_items = 0;
      while (work_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) send_noise();
        drive_segment();
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
